@@ design/tscs_pkg.sv @@
// ----------------------------------------------------------------------------
// tscs_pkg: shared types and constants
// Codes, field layouts and fixed-point sizes for the torque sweep calibrator.
// ----------------------------------------------------------------------------
package tscs_pkg;

    // Moving-window depth for the angle average
    localparam int WINDOW_LEN = 50;
    localparam int WIN_LOG    = $clog2(WINDOW_LEN);

    // Window sum holds WINDOW_LEN signed 16-bit samples
    localparam int SUM_W  = WIN_LOG + 16;
    // Divide by WINDOW_LEN as multiply by a rounded-up reciprocal
    localparam int DIV_SH = SUM_W + WIN_LOG + 1;
    localparam int MUL_W  = DIV_SH - WIN_LOG + 1;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_SH) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));
    localparam int QUO_W  = 17;

    localparam int TIMER_W = 17;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam int SWEEP_W = 17;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;
    localparam int FUNC_W      = 2;
    localparam int EVENT_W     = 3;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 2'd0,
        FN_START = 2'd1,
        FN_ABORT = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_INIT   = 3'd1,
        PH_RAMP   = 3'd2,
        PH_SETTLE = 3'd3,
        PH_RECORD = 3'd4,
        PH_NEXT   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_BEGIN = 3'd1,
        EV_ROW   = 3'd2,
        EV_END   = 3'd3,
        EV_ABORT = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        REG_TORQUE_START = 3'd0,
        REG_TORQUE_STEP  = 3'd1,
        REG_TORQUE_END   = 3'd2,
        REG_TICK_PERIOD  = 3'd3,
        REG_SETTLE_TIME  = 3'd4,
        REG_RECORD_TIME  = 3'd5
    } t_reg_idx;

    // Window cell control
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

    // Input tdata, last field in the low bits
    typedef struct packed {
        logic signed [15:0] normal_reference;
        logic signed [15:0] measured_torque;
        logic signed [15:0] pitch_angle;
    } t_in_data;

    // Output tdata, last field in the low bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        row_count;
        logic signed [15:0] row_measured_torque;
        logic signed [15:0] row_avg_angle;
        logic signed [15:0] row_target_torque;
        logic               open_loop;
        logic signed [15:0] torque_cmd;
        logic               torque_valid;
        logic               active;
    } t_out_data;

    // First pipeline stage: everything but the average
    typedef struct packed {
        logic               active;
        logic               torque_valid;
        logic signed [15:0] torque_cmd;
        logic               open_loop;
        t_event             event_res;
        logic signed [15:0] row_target_torque;
        logic signed [15:0] row_measured_torque;
        logic [15:0]        row_count;
        logic signed [SUM_W-1:0] win_sum;
    } t_stage;

endpackage

@@ design/tscs_win_cell.sv @@
// ----------------------------------------------------------------------------
// tscs_win_cell: one sample slot of the angle window
// Holds one pitch sample; shifts it to the next slot on a push, zeroes on clear.
// ----------------------------------------------------------------------------
module tscs_win_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tscs_pkg::t_cell_ctl  i_ctl,
    input  logic signed [15:0]   i_d,
    output logic signed [15:0]   o_q
);
    import tscs_pkg::*;

    logic signed [15:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.clear) begin
            r_q <= '0;
        end else if (i_ctl.shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ design/tscs_avg_div.sv @@
// ----------------------------------------------------------------------------
// tscs_avg_div: window average
// Window sum divided by WINDOW_LEN, truncated toward zero, via reciprocal.
// ----------------------------------------------------------------------------
module tscs_avg_div (
    input  logic signed [tscs_pkg::SUM_W-1:0] i_sum,
    output logic signed [15:0]                o_avg
);
    import tscs_pkg::*;

    logic                     w_neg;
    logic [SUM_W-1:0]         w_abs;
    logic [SUM_W+MUL_W-1:0]   w_prod;
    logic [QUO_W-1:0]         w_quo;
    logic [QUO_W-1:0]         w_res;

    assign w_neg  = i_sum[SUM_W-1];
    assign w_abs  = w_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_prod = (SUM_W+MUL_W)'(w_abs) * (SUM_W+MUL_W)'(DIV_MUL);
    // magnitude quotient, then restore the sign
    assign w_quo  = w_prod[DIV_SH +: QUO_W];
    assign w_res  = w_neg ? (~w_quo + QUO_W'(1)) : w_quo;
    assign o_avg  = w_res[15:0];

endmodule

@@ design/torque_sweep_calibration_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// torque_sweep_calibration_sequencer_unit: open-loop torque sweep calibrator
// Steps a torque command through a sweep and reports averaged pitch per point.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns exactly one result transaction
// for each, in order. There are two register stages: the first decodes the
// request, advances the sweep sequencer and pushes the pitch sample through
// the window cell chain (running-sum update); the second turns the window sum
// into the average with a single reciprocal multiply and holds the finished
// result in the output register. While a result waits at the output, one more
// transaction is taken into the first stage; after that s_axis_tready follows
// m_axis_tready, and a full pipe still moves one transaction per clock
// whenever the result side takes one. tuser selects the request: tick, start
// or abort. The user must write settings over the APB port only while no
// transaction is in flight; the block does not check it. pready is tied high.
// ----------------------------------------------------------------------------
module torque_sweep_calibration_sequencer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] pitch_angle, [31:16] measured_torque, [47:32] normal_reference
    input  logic [tscs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [tscs_pkg::FUNC_W-1:0]         s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] active, [1] torque_valid, [17:2] torque_cmd, [18] open_loop,
    // [34:19] row_target_torque, [50:35] row_avg_angle,
    // [66:51] row_measured_torque, [82:67] row_count, [87:83] zero
    output logic [tscs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [2:0] event_res
    output logic [tscs_pkg::EVENT_W-1:0]        m_axis_tuser,
    // settings port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tscs_pkg::APB_AW-1:0]         paddr,
    input  logic [tscs_pkg::APB_DW-1:0]         pwdata,
    output logic [tscs_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import tscs_pkg::*;

    // ---------------- settings registers ----------------
    logic signed [15:0] r_torque_start;
    logic signed [15:0] r_torque_step;
    logic signed [15:0] r_torque_end;
    logic [7:0]         r_tick_period;
    logic [15:0]        r_settle_time;
    logic [15:0]        r_record_time;

    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_start <= 16'sd0;
            r_torque_step  <= 16'sd100;
            r_torque_end   <= 16'sd1000;
            r_tick_period  <= 8'd1;
            r_settle_time  <= 16'd1000;
            r_record_time  <= 16'd500;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_TORQUE_START: r_torque_start <= pwdata[15:0];
                REG_TORQUE_STEP:  r_torque_step  <= pwdata[15:0];
                REG_TORQUE_END:   r_torque_end   <= pwdata[15:0];
                REG_TICK_PERIOD:  r_tick_period  <= pwdata[7:0];
                REG_SETTLE_TIME:  r_settle_time  <= pwdata[15:0];
                REG_RECORD_TIME:  r_record_time  <= pwdata[15:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TORQUE_START: prdata = APB_DW'(unsigned'(r_torque_start));
            REG_TORQUE_STEP:  prdata = APB_DW'(unsigned'(r_torque_step));
            REG_TORQUE_END:   prdata = APB_DW'(unsigned'(r_torque_end));
            REG_TICK_PERIOD:  prdata = APB_DW'(r_tick_period);
            REG_SETTLE_TIME:  prdata = APB_DW'(r_settle_time);
            REG_RECORD_TIME:  prdata = APB_DW'(r_record_time);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    // Stage 1 register -> output register. Everything moves when the output
    // register is free or being drained this cycle.
    logic   r_s1_valid;
    t_stage r_s1;
    logic   r_out_valid;
    t_out_data r_out_data;
    t_event r_out_event;

    logic w_adv;
    logic w_acc;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------- sequencer state ----------------
    t_phase                    r_phase,       n_phase;
    logic [TIMER_W-1:0]        r_timer,       n_timer;
    logic signed [SWEEP_W-1:0] r_sweep,       n_sweep;
    logic signed [15:0]        r_saved_ref,   n_saved_ref;
    logic                      r_backup,      n_backup;
    logic                      r_export,      n_export;
    logic [15:0]               r_rows,        n_rows;
    logic signed [SUM_W-1:0]   r_sum,         n_sum;
    logic                      r_drive_open,  n_drive_open;
    logic                      r_saved_open,  n_saved_open;

    t_in_data w_in;
    t_func    w_func;
    t_stage   w_s1;

    assign w_in   = t_in_data'(s_axis_tdata);
    assign w_func = t_func'(s_axis_tuser);

    // timer add with saturation at the 17-bit ceiling
    logic [TIMER_W:0]   w_tsum;
    logic [TIMER_W-1:0] w_tsat;
    assign w_tsum = {1'b0, r_timer} + (TIMER_W+1)'(r_tick_period);
    assign w_tsat = w_tsum[TIMER_W] ? TIMER_MAX : w_tsum[TIMER_W-1:0];

    // next sweep point, clamped to the 17-bit signed range
    logic signed [SWEEP_W:0]   w_sw_sum;
    logic signed [SWEEP_W-1:0] w_sw_sat;
    assign w_sw_sum = (SWEEP_W+1)'(r_sweep) + (SWEEP_W+1)'(r_torque_step);
    always_comb begin
        unique case (w_sw_sum[SWEEP_W:SWEEP_W-1])
            2'b01:   w_sw_sat = {1'b0, {(SWEEP_W-1){1'b1}}};
            2'b10:   w_sw_sat = {1'b1, {(SWEEP_W-1){1'b0}}};
            default: w_sw_sat = w_sw_sum[SWEEP_W-1:0];
        endcase
    end

    // commanded torque: sweep point clamped to 16 bits
    logic signed [15:0] w_cmd_sat;
    always_comb begin
        unique case (r_sweep[SWEEP_W-1:SWEEP_W-2])
            2'b01:   w_cmd_sat = 16'sh7FFF;
            2'b10:   w_cmd_sat = 16'sh8000;
            default: w_cmd_sat = r_sweep[15:0];
        endcase
    end

    // window chain tail and running-sum update
    logic signed [15:0]      w_cell_q [WINDOW_LEN];
    logic signed [SUM_W-1:0] w_push_sum;
    assign w_push_sum = r_sum - SUM_W'(w_cell_q[WINDOW_LEN-1])
                      + SUM_W'(w_in.pitch_angle);

    logic w_push;
    logic w_clear;
    t_cell_ctl w_cell_ctl;

    always_comb begin
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_sweep      = r_sweep;
        n_saved_ref  = r_saved_ref;
        n_backup     = r_backup;
        n_export     = r_export;
        n_rows       = r_rows;
        n_sum        = r_sum;
        n_drive_open = r_drive_open;
        n_saved_open = r_saved_open;
        w_push       = 1'b0;
        w_clear      = 1'b0;
        w_s1         = '0;
        w_s1.event_res = EV_NONE;

        unique case (w_func)
            FN_START: begin
                if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                    n_backup = 1'b0;
                    n_export = 1'b0;
                    n_rows   = '0;
                    n_phase  = PH_INIT;
                end
            end
            FN_ABORT: begin
                if (r_phase != PH_IDLE) begin
                    w_s1.torque_valid = 1'b1;
                    if (r_backup) begin
                        w_s1.torque_cmd = r_saved_ref;
                        n_drive_open    = r_saved_open;
                    end
                    if (r_export) begin
                        w_s1.event_res = EV_ABORT;
                        w_s1.row_count = r_rows;
                    end
                    n_timer  = '0;
                    n_sweep  = '0;
                    n_backup = 1'b0;
                    n_export = 1'b0;
                    n_rows   = '0;
                    n_sum    = '0;
                    w_clear  = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            FN_TICK: begin
                if (r_phase != PH_IDLE) begin
                    w_s1.active = 1'b1;
                    unique case (r_phase)
                        PH_INIT: begin
                            n_saved_open   = r_drive_open;
                            n_saved_ref    = w_in.normal_reference;
                            n_backup       = 1'b1;
                            n_drive_open   = 1'b1;
                            n_sweep        = SWEEP_W'(r_torque_start);
                            n_timer        = '0;
                            n_rows         = '0;
                            n_export       = 1'b1;
                            w_s1.event_res = EV_BEGIN;
                            n_phase        = PH_RAMP;
                        end
                        PH_RAMP: begin
                            w_s1.torque_valid = 1'b1;
                            w_s1.torque_cmd   = w_cmd_sat;
                            n_timer           = '0;
                            n_phase           = PH_SETTLE;
                        end
                        PH_SETTLE: begin
                            w_s1.torque_valid = 1'b1;
                            w_s1.torque_cmd   = w_cmd_sat;
                            n_timer           = w_tsat;
                            if (w_tsat >= TIMER_W'(r_settle_time)) begin
                                w_clear = 1'b1;
                                n_sum   = '0;
                                n_timer = '0;
                                n_phase = PH_RECORD;
                            end
                        end
                        PH_RECORD: begin
                            w_s1.torque_valid = 1'b1;
                            w_s1.torque_cmd   = w_cmd_sat;
                            w_push            = 1'b1;
                            n_sum             = w_push_sum;
                            n_timer           = w_tsat;
                            if (w_tsat >= TIMER_W'(r_record_time)) begin
                                w_s1.event_res           = EV_ROW;
                                w_s1.row_target_torque   = w_cmd_sat;
                                w_s1.row_measured_torque = w_in.measured_torque;
                                w_s1.win_sum             = w_push_sum;
                                if (r_rows != '1) begin
                                    n_rows = r_rows + 16'd1;
                                end
                                n_phase = PH_NEXT;
                            end
                        end
                        PH_NEXT: begin
                            n_sweep = w_sw_sat;
                            n_phase = (w_sw_sat > SWEEP_W'(r_torque_end)) ?
                                      PH_DONE : PH_RAMP;
                        end
                        PH_DONE: begin
                            w_s1.torque_valid = 1'b1;
                            if (r_backup) begin
                                w_s1.torque_cmd = r_saved_ref;
                                n_drive_open    = r_saved_open;
                            end
                            if (r_export) begin
                                w_s1.event_res = EV_END;
                                w_s1.row_count = r_rows;
                            end
                            n_backup = 1'b0;
                            n_export = 1'b0;
                            n_rows   = '0;
                            n_phase  = PH_IDLE;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            default: ;  // unused request code: no effect
        endcase

        w_s1.open_loop = n_drive_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_timer      <= '0;
            r_sweep      <= '0;
            r_saved_ref  <= '0;
            r_backup     <= 1'b0;
            r_export     <= 1'b0;
            r_rows       <= '0;
            r_sum        <= '0;
            r_drive_open <= 1'b0;
            r_saved_open <= 1'b0;
        end else if (w_acc) begin
            r_phase      <= n_phase;
            r_timer      <= n_timer;
            r_sweep      <= n_sweep;
            r_saved_ref  <= n_saved_ref;
            r_backup     <= n_backup;
            r_export     <= n_export;
            r_rows       <= n_rows;
            r_sum        <= n_sum;
            r_drive_open <= n_drive_open;
            r_saved_open <= n_saved_open;
        end
    end

    // ---------------- angle window: chain of sample cells ----------------
    // A push moves every sample one cell down; the last cell holds the
    // oldest sample, which leaves the running sum.
    assign w_cell_ctl.shift = w_acc && w_push;
    assign w_cell_ctl.clear = w_acc && w_clear;

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_win
        logic signed [15:0] w_d;
        if (g == 0) begin : g_head
            assign w_d = w_in.pitch_angle;
        end else begin : g_link
            assign w_d = w_cell_q[g-1];
        end
        tscs_win_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cell_ctl),
            .i_d     (w_d),
            .o_q     (w_cell_q[g])
        );
    end

    // ---------------- stage 1 register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= w_s1;
        end
    end

    // ---------------- stage 2: average and output register ----------------
    logic signed [15:0] w_avg;
    t_out_data          w_out;

    tscs_avg_div u_avg (
        .i_sum (r_s1.win_sum),
        .o_avg (w_avg)
    );

    always_comb begin
        w_out                     = '0;
        w_out.active              = r_s1.active;
        w_out.torque_valid        = r_s1.torque_valid;
        w_out.torque_cmd          = r_s1.torque_cmd;
        w_out.open_loop           = r_s1.open_loop;
        w_out.row_target_torque   = r_s1.row_target_torque;
        w_out.row_avg_angle       = w_avg;  // sum is zero off row events
        w_out.row_measured_torque = r_s1.row_measured_torque;
        w_out.row_count           = r_s1.row_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_data  <= w_out;
            r_out_event <= r_s1.event_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_event;

endmodule

@@ design/tscs_chk.sv @@
// ----------------------------------------------------------------------------
// tscs_chk: port-level checks for the torque sweep calibrator
// Watches the result stream over time; bound to the top level.
// ----------------------------------------------------------------------------
module tscs_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [tscs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [tscs_pkg::EVENT_W-1:0]     m_axis_tuser
);
    import tscs_pkg::*;

    t_out_data w_out;
    assign w_out = t_out_data'(m_axis_tdata);

    // no result appears straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a row comes from a tick in open loop with a live torque command
    a_row_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_ROW |->
            w_out.active && w_out.torque_valid && w_out.open_loop
            && w_out.torque_cmd == w_out.row_target_torque)
        else $error("row event outside a record tick");

    // begin switches to open loop without sending a reference
    a_begin_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_BEGIN |->
            w_out.open_loop && !w_out.torque_valid && w_out.active)
        else $error("begin event with wrong drive state");

    // no reference means a zero command field
    a_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_out.torque_valid |-> w_out.torque_cmd == 16'sd0)
        else $error("torque command without torque_valid");

endmodule

bind torque_sweep_calibration_sequencer_unit tscs_chk u_tscs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: torque sweep calibrator testbench
// Runs the sequencer through directed corner sweeps and then many random
// sweeps under changing settings. Each accepted request is fed to a model of
// the sweep state held here, and every result transaction is checked field by
// field against the oldest expected result. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tscs_pkg::*;

    // func code the block leaves unused
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int SWEEP_HI   = 65535;     // 17-bit signed sweep range
    localparam int SWEEP_LO   = -65536;
    localparam int ROWS_MAX   = 65535;
    localparam int WORK_ITEMS = 1550;      // requests that do real work
    localparam int QUIET_FROM = 1300;      // no idling past this point
    localparam int DRAIN_CYC  = 6;         // two pipeline stages plus margin

    // One expected result transaction: tdata fields plus the tuser event
    typedef struct packed {
        t_out_data data;
        t_event    ev;
    } t_sweep_reply;

    // ------------------------------------------------------------------------
    // Sweep tracker: mirrors the sequencer state, queues the result due for
    // every accepted request and checks what comes out of the block.
    // ------------------------------------------------------------------------
    class sweep_tracker;
        // settings
        logic signed [15:0] cfg_start, cfg_step, cfg_stop;
        logic [7:0]         cfg_period;
        logic [15:0]        cfg_settle, cfg_record;
        // sequencer state
        t_phase             phase;
        int unsigned        timer;
        int                 sweep;
        logic signed [15:0] saved_ref;
        bit                 backup_valid, export_open, drive_open, saved_open;
        int unsigned        rows_done;
        int                 pitch_window [WINDOW_LEN];
        int                 pitch_sum;
        int                 pitch_ptr;
        // results still owed by the block, oldest first
        t_sweep_reply       replies_due [$];
        int                 mismatches;
        int                 checked;

        function new();
            cfg_start    = 16'sd0;
            cfg_step     = 16'sd100;
            cfg_stop     = 16'sd1000;
            cfg_period   = 8'd1;
            cfg_settle   = 16'd1000;
            cfg_record   = 16'd500;
            phase        = PH_IDLE;
            timer        = 0;
            sweep        = 0;
            saved_ref    = '0;
            backup_valid = 0;
            export_open  = 0;
            drive_open   = 0;
            saved_open   = 0;
            rows_done    = 0;
            mismatches   = 0;
            checked      = 0;
            clear_window();
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] v);
            case (idx)
                REG_TORQUE_START: cfg_start  = v;
                REG_TORQUE_STEP:  cfg_step   = v;
                REG_TORQUE_END:   cfg_stop   = v;
                REG_TICK_PERIOD:  cfg_period = v[7:0];
                REG_SETTLE_TIME:  cfg_settle = v;
                REG_RECORD_TIME:  cfg_record = v;
                default: ;
            endcase
        endfunction

        function logic signed [15:0] clip16(int v);
            if (v > 32767)  return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function void clear_window();
            foreach (pitch_window[i]) pitch_window[i] = 0;
            pitch_sum = 0;
            pitch_ptr = 0;
        endfunction

        // timer saturates at the 17-bit ceiling
        function void add_tick();
            int unsigned t;
            t = timer + cfg_period;
            timer = (t > TIMER_MAX) ? TIMER_MAX : t;
        endfunction

        // running-sum window, average truncates toward zero
        function int push_pitch(int x);
            int p;
            p = (pitch_ptr < WINDOW_LEN) ? pitch_ptr : 0;
            pitch_sum = pitch_sum - pitch_window[p] + x;
            pitch_window[p] = x;
            pitch_ptr = (p + 1 >= WINDOW_LEN) ? 0 : p + 1;
            return pitch_sum / WINDOW_LEN;
        endfunction

        // hand control back; reference is 0 when nothing was saved
        function logic signed [15:0] hand_back();
            if (backup_valid) begin
                drive_open = saved_open;
                return saved_ref;
            end
            return '0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic signed [15:0] pitch,
                                   logic signed [15:0] meas, logic signed [15:0] nref);
            t_sweep_reply r;
            int           avg;
            int           nxt;
            r    = '0;
            r.ev = EV_NONE;
            if (func == FN_START) begin
                // only taken from idle or done; backup flag drops right here
                if (phase == PH_IDLE || phase == PH_DONE) begin
                    backup_valid = 0;
                    export_open  = 0;
                    rows_done    = 0;
                    phase        = PH_INIT;
                end
            end else if (func == FN_ABORT) begin
                if (phase != PH_IDLE) begin
                    r.data.torque_valid = 1'b1;
                    r.data.torque_cmd   = hand_back();
                    if (export_open) begin
                        r.ev             = EV_ABORT;
                        r.data.row_count = rows_done[15:0];
                    end
                    timer        = 0;
                    sweep        = 0;
                    backup_valid = 0;
                    export_open  = 0;
                    rows_done    = 0;
                    clear_window();
                    phase        = PH_IDLE;
                end
            end else if (func == FN_TICK && phase != PH_IDLE) begin
                r.data.active = 1'b1;
                case (phase)
                    PH_INIT: begin
                        saved_open   = drive_open;
                        saved_ref    = nref;
                        backup_valid = 1;
                        drive_open   = 1;
                        sweep        = cfg_start;
                        timer        = 0;
                        rows_done    = 0;
                        export_open  = 1;
                        r.ev         = EV_BEGIN;
                        phase        = PH_RAMP;
                    end
                    PH_RAMP: begin
                        r.data.torque_valid = 1'b1;
                        r.data.torque_cmd   = clip16(sweep);
                        timer               = 0;
                        phase               = PH_SETTLE;
                    end
                    PH_SETTLE: begin
                        r.data.torque_valid = 1'b1;
                        r.data.torque_cmd   = clip16(sweep);
                        add_tick();
                        if (timer >= cfg_settle) begin
                            clear_window();
                            timer = 0;
                            phase = PH_RECORD;
                        end
                    end
                    PH_RECORD: begin
                        r.data.torque_valid = 1'b1;
                        r.data.torque_cmd   = clip16(sweep);
                        avg = push_pitch(pitch);
                        add_tick();
                        if (timer >= cfg_record) begin
                            r.ev                       = EV_ROW;
                            r.data.row_target_torque   = r.data.torque_cmd;
                            r.data.row_avg_angle       = clip16(avg);
                            r.data.row_measured_torque = meas;
                            if (rows_done < ROWS_MAX) rows_done++;
                            phase = PH_NEXT;
                        end
                    end
                    PH_NEXT: begin
                        nxt = sweep + cfg_step;
                        if (nxt > SWEEP_HI) nxt = SWEEP_HI;
                        if (nxt < SWEEP_LO) nxt = SWEEP_LO;
                        sweep = nxt;
                        phase = (nxt > cfg_stop) ? PH_DONE : PH_RAMP;
                    end
                    PH_DONE: begin
                        r.data.torque_valid = 1'b1;
                        r.data.torque_cmd   = hand_back();
                        if (export_open) begin
                            r.ev             = EV_END;
                            r.data.row_count = rows_done[15:0];
                        end
                        backup_valid = 0;
                        export_open  = 0;
                        rows_done    = 0;
                        phase        = PH_IDLE;
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            r.data.open_loop = drive_open;
            replies_due.push_back(r);
        endfunction

        function void compare_field(string fname, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            if (got_v === want_v) return;
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d, %s: expected %0d, got %0d",
                         checked, fname, want_v, got_v);
        endfunction

        function void check_reply(t_out_data got, logic [EVENT_W-1:0] got_ev);
            t_sweep_reply want;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing pending", checked);
                checked++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("active",              want.data.active,       got.active);
            compare_field("torque_valid",        want.data.torque_valid, got.torque_valid);
            compare_field("torque_cmd",          want.data.torque_cmd,   got.torque_cmd);
            compare_field("open_loop",           want.data.open_loop,    got.open_loop);
            compare_field("event_res",           want.ev,                got_ev);
            compare_field("row_target_torque",   want.data.row_target_torque,
                          got.row_target_torque);
            compare_field("row_avg_angle",       want.data.row_avg_angle,
                          got.row_avg_angle);
            compare_field("row_measured_torque", want.data.row_measured_torque,
                          got.row_measured_torque);
            compare_field("row_count",           want.data.row_count,    got.row_count);
            compare_field("pad",                 want.data.pad,          got.pad);
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known level
    // ------------------------------------------------------------------------
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [FUNC_W-1:0]       s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [EVENT_W-1:0]      m_axis_tuser;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_AW-1:0]       paddr         = '0;
    logic [APB_DW-1:0]       pwdata        = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    torque_sweep_calibration_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sweep_tracker tracker = new();
    int           work_items = 0;     // requests the block actually acts on
    bit           idle_on    = 1'b1;  // random idling on both sides
    int           stall_left = 0;

    always #1 i_clk = ~i_clk;

    // Result side: tready drops in random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every result transaction goes straight to the tracker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_reply(t_out_data'(m_axis_tdata), m_axis_tuser);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Back-to-back APB writes keep psel high; caller drops it after the last
    task automatic apb_write(t_reg_idx idx, logic [15:0] v);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= {16'h0000, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        tracker.set_reg(idx, v);
    endtask

    task automatic load_settings(int t_start, int t_step, int t_stop,
                                 int period, int settle, int rec);
        apb_write(REG_TORQUE_START, 16'(t_start));
        apb_write(REG_TORQUE_STEP,  16'(t_step));
        apb_write(REG_TORQUE_END,   16'(t_stop));
        apb_write(REG_TICK_PERIOD,  16'(period));
        apb_write(REG_SETTLE_TIME,  16'(settle));
        apb_write(REG_RECORD_TIME,  16'(rec));
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One request transaction; tvalid stays up afterwards unless a gap follows
    task automatic send_req(logic [FUNC_W-1:0] func, logic signed [15:0] pitch,
                            logic signed [15:0] meas, logic signed [15:0] nref);
        bit does_work;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {nref, meas, pitch};
        do @(posedge i_clk); while (!s_axis_tready);
        // ignored requests don't count toward the run length
        does_work = (func == FN_TICK  && tracker.phase != PH_IDLE) ||
                    (func == FN_ABORT && tracker.phase != PH_IDLE) ||
                    (func == FN_START && (tracker.phase == PH_IDLE ||
                                          tracker.phase == PH_DONE));
        tracker.note_request(func, pitch, meas, nref);
        if (does_work) work_items++;
        idle_on = (work_items < QUIET_FROM);
    endtask

    task automatic send_rand(logic [FUNC_W-1:0] func);
        int pitch;
        pitch = int'($urandom_range(0, 36000)) - 18000;
        send_req(func, 16'(pitch), 16'($urandom), 16'($urandom));
    endtask

    // Drop tvalid and wait until every result is back, then let the pipe empty
    task automatic settle_out();
        s_axis_tvalid <= 1'b0;
        while (tracker.replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // A full sweep with random content, some noise mixed in, aborted on budget
    // or once the run has done enough work
    task automatic run_sweep(int budget);
        int n;
        int pick;
        case ($urandom_range(0, 7))
            0: send_rand(FN_TICK);     // tick while idle
            1: send_rand(FN_ABORT);    // abort while idle
            2: send_rand(FN_UNUSED);
            default: ;
        endcase
        send_rand(FN_START);
        n = 0;
        while (tracker.phase != PH_IDLE && n < budget && work_items < WORK_ITEMS) begin
            pick = $urandom_range(0, 199);
            if (pick < 3)      send_rand(FN_START);   // busy, or from done
            else if (pick < 5) send_rand(FN_UNUSED);
            else if (pick < 6) send_rand(FN_ABORT);
            else               send_rand(FN_TICK);
            n++;
        end
        if (tracker.phase != PH_IDLE) send_rand(FN_ABORT);
    endtask

    // Random settings; long record windows, dead timer and endless sweeps now
    // and then
    task automatic pick_settings(output int budget);
        int mode, period, settle_v, rec_v, start_v, step_v, stop_v;
        mode   = $urandom_range(0, 11);
        period = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : 1;
        if (mode == 0) period = 0;
        settle_v = $urandom_range(0, 6 * (period + 1));
        if (mode == 1 || mode == 2)
            rec_v = $urandom_range(50 * period, 65 * period);   // window wraps
        else
            rec_v = $urandom_range(0, 12 * period);
        start_v = int'($urandom_range(0, 4000)) - 2000;
        step_v  = $urandom_range(1, 1500);
        if (mode == 3) step_v = -int'($urandom_range(0, 400));
        if (mode == 4) begin
            start_v = $urandom_range(0, 1) ? -32768 : 32767;
            step_v  = $urandom_range(0, 1) ? 32767 : 20000;
        end
        stop_v = start_v + step_v * int'($urandom_range(0, 3));
        if (stop_v > 32767)  stop_v = 32767;
        if (stop_v < -32768) stop_v = -32768;
        budget = (period == 0 || step_v <= 0) ? 60 : 400;
        load_settings(start_v, step_v, stop_v, period, settle_v, rec_v);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int budget;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Deepest negative sweep, fastest timer, zero settle and record
        load_settings(-32768, -32768, 32767, 255, 0, 0);
        send_rand(FN_TICK);                            // tick while idle
        send_rand(FN_ABORT);                           // abort while idle
        send_rand(FN_UNUSED);
        send_rand(FN_START);
        send_rand(FN_START);                           // start while busy
        send_rand(FN_ABORT);                           // abort before first tick
        send_rand(FN_START);
        send_req(FN_TICK, 16'sd0, 16'sd0, -16'sd32768);     // begin, save ref
        send_rand(FN_TICK);                                 // ramp
        send_rand(FN_TICK);                                 // settle, one tick
        send_req(FN_TICK, 16'sd18000, 16'sd32767, 16'sd0);  // row
        send_rand(FN_TICK);                            // sweep lands on the 17-bit floor
        send_rand(FN_TICK);                            // command clips to 16 bits
        send_rand(FN_TICK);
        send_req(FN_TICK, -16'sd18000, -16'sd32768, 16'sd0);
        send_rand(FN_ABORT);                           // abort with two rows
        settle_out();

        // Highest sweep, ends after one point; restart straight from done
        load_settings(32767, 32767, -32768, 1, 1, 1);
        send_rand(FN_START);
        send_req(FN_TICK, 16'sd0, 16'sd0, 16'sd32767);
        repeat (4) send_rand(FN_TICK);                 // ramp, settle, row, next
        send_rand(FN_START);                           // start from done
        repeat (5) send_rand(FN_TICK);                 // begin saves open loop
        send_rand(FN_TICK);                            // end, restores open loop
        settle_out();

        // Random sweeps under changing settings
        while (work_items < WORK_ITEMS) begin
            pick_settings(budget);
            repeat ($urandom_range(2, 5))
                if (work_items < WORK_ITEMS) run_sweep(budget);
            settle_out();
        end

        if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/tscs_pkg.sv
design/tscs_win_cell.sv
design/tscs_avg_div.sv
design/torque_sweep_calibration_sequencer_unit.sv
design/tscs_chk.sv
test/tb_top.sv
